### sv/bf_pkg.sv
`default_nettype none
package bf_pkg;

  localparam int DEF_TAPE_DEPTH    = 32768;
  localparam int DEF_PROGRAM_DEPTH = 4096;
  localparam int DEF_STACK_DEPTH   = 128;
  localparam int DEF_INPUT_DEPTH   = 1024;

  localparam logic [15:0] TAPE_LEN_RESET = 16'd30000;

  // tag bits kept next to each tape cell
  localparam int EPOCH_W = 4;

  typedef enum logic [1:0] {
    OP_LOAD_PROG  = 2'd0,
    OP_LOAD_INPUT = 2'd1,
    OP_EXEC       = 2'd2,
    OP_RESTART    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_INPUT  = 3'd1,
    ST_PLUGIN    = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_BANG  = 8'h21;

  typedef struct packed {
    logic wr_en;
    logic restart;
  } tape_ctl_t;

endpackage
`default_nettype wire

### sv/bf_in_if.sv
`default_nettype none
interface bf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] symbol;

  modport source (output valid, output opcode, output symbol, input ready);
  modport sink (input valid, input opcode, input symbol, output ready);
endinterface
`default_nettype wire

### sv/bf_out_if.sv
`default_nettype none
interface bf_out_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        halted;
  logic [2:0]  status;
  logic [12:0] program_position;

  modport source (output valid, output out_valid, output out_byte, output halted,
                  output status, output program_position, input ready);
  modport sink (input valid, input out_valid, input out_byte, input halted,
                input status, input program_position, output ready);
endinterface
`default_nettype wire

### sv/bf_ram.sv
`default_nettype none
module bf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/bf_tape.sv
`default_nettype none
module bf_tape import bf_pkg::*; #(
  parameter int TAPE_DEPTH = DEF_TAPE_DEPTH,
  localparam int AW = $clog2(TAPE_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tape_ctl_t       ctl,
  input  wire logic [AW-1:0]   rd_addr,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire logic [7:0]      wr_data,
  output logic      [7:0]      rd_data,
  output logic                 busy
);

  logic [EPOCH_W-1:0] epoch;
  logic [EPOCH_W-1:0] gen;
  logic               clearing;
  logic [AW-1:0]      clr_addr;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [EPOCH_W+7:0] ram_wdata;
  logic [EPOCH_W+7:0] ram_rdata;

  // a cell whose tag is from an older epoch reads as cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch    <= '0;
      gen      <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(TAPE_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (ctl.restart) begin
        epoch <= epoch + EPOCH_W'(1);
        if (gen == '1) begin
          gen      <= '0;
          clearing <= 1'b1;
          clr_addr <= '0;
        end else begin
          gen <= gen + EPOCH_W'(1);
        end
      end
    end
  end

  assign ram_we    = clearing || ctl.wr_en;
  assign ram_waddr = clearing ? clr_addr : wr_addr;
  assign ram_wdata = {epoch, (clearing ? 8'd0 : wr_data)};

  bf_ram #(.WIDTH(EPOCH_W + 8), .DEPTH(TAPE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign rd_data = (ram_rdata[EPOCH_W+7:8] == epoch) ? ram_rdata[7:0] : 8'd0;
  assign busy    = clearing;

  a_clear_start: assert property (@(posedge clk) disable iff (rst)
    ($rose(clearing) |-> clr_addr == '0))
    else $error("tape clear did not start at entry zero");

  a_gen_wrap: assert property (@(posedge clk) disable iff (rst)
    (ctl.restart && gen == '1 |=> clearing))
    else $error("epoch wrapped without a clearing pass");

  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    (clearing && clr_addr == AW'(TAPE_DEPTH - 1) && !ctl.restart |=> !clearing))
    else $error("clearing pass overran the tape");

endmodule
`default_nettype wire

### sv/bf_tape_machine_step.sv
// Tape machine for the eight-symbol language.
// cmd carries one command per beat: load a program symbol, load an input
// byte, execute one instruction, or restart. result returns exactly one
// beat per command with the emitted byte, halt flag, status and program
// counter. Both channels use valid/ready; a beat moves when both are high.
// cfg_write with cfg_data sets the tape length; the user must write it only
// while no command is in flight, as the block itself does not enforce it.
// From a cmd beat, loads and an execute on a halted machine go straight to
// S_DONE; restart passes through S_CLEAR and an executed instruction through
// S_FETCH first. S_SKIP scans one program symbol per cycle when '[' skips
// forward over a zero cell, and makes one last check when no match is found.
// One command is in work at a time; the next one is taken once the previous
// result sits in the output register.
// The program, tape, stack and input memories each have one registered
// read port; an instruction writes at most once, to the tape or the stack.
// After reset, and on every 16th restart, the tape is swept clear with
// cmd.ready low. Other restarts clear it at once by an epoch tag per cell.
// If result.ready stays low the finished result holds, and the next command
// waits in S_DONE with cmd.ready low.
`default_nettype none
module bf_tape_machine_step import bf_pkg::*; #(
  parameter int TAPE_DEPTH    = DEF_TAPE_DEPTH,
  parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
  parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
  parameter int INPUT_DEPTH   = DEF_INPUT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  bf_in_if.sink            cmd,
  bf_out_if.source         result
);

  localparam int PTRW = $clog2(TAPE_DEPTH);
  localparam int LENW = $clog2(TAPE_DEPTH + 1);
  localparam int PAW  = $clog2(PROGRAM_DEPTH);
  localparam int PCW  = $clog2(PROGRAM_DEPTH + 1);
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int SDW  = $clog2(STACK_DEPTH + 1);
  localparam int IAW  = $clog2(INPUT_DEPTH);
  localparam int ICW  = $clog2(INPUT_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_SKIP  = 5'b00100,
    S_CLEAR = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t          state;
  logic [15:0]     tape_length;
  logic [PCW-1:0]  pc;
  logic [PCW-1:0]  pcount;
  logic [PTRW-1:0] ptr;
  logic [SDW-1:0]  sdepth;
  logic [ICW-1:0]  icount;
  logic [IAW-1:0]  rp;
  logic [PCW-1:0]  scan;
  logic [PCW-1:0]  level;
  status_t         st;
  logic            emit_v;
  logic [7:0]      emit_b;

  logic            res_valid;
  logic            res_out_valid;
  logic [7:0]      res_out_byte;
  logic            res_halted;
  logic [2:0]      res_status;
  logic [12:0]     res_position;

  logic            accept;
  logic            tape_busy;
  tape_ctl_t       tape_ctl;
  logic [7:0]      tape_wdata;
  logic [7:0]      cur_cell;
  logic [LENW-1:0] used_len;

  logic            prog_we;
  logic [PAW-1:0]  prog_raddr;
  logic [7:0]      instr;
  logic            stack_we;
  logic [PAW-1:0]  stack_rdata;
  logic            in_we;
  logic [IAW-1:0]  rp_eff;
  logic [IAW-1:0]  rp_adv;
  logic [7:0]      in_rdata;

  assign cmd.ready = (state == S_IDLE) && !tape_busy;
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    if (tape_length == 16'd0) begin
      used_len = LENW'(1);
    end else if ({1'b0, tape_length} > 17'(TAPE_DEPTH)) begin
      used_len = LENW'(TAPE_DEPTH);
    end else begin
      used_len = LENW'(tape_length);
    end
  end

  // input read pointer folds back when it runs past the loaded bytes
  always_comb begin
    rp_eff = (ICW'(rp) >= icount) ? '0 : rp;
    rp_adv = (ICW'(rp_eff) + ICW'(1) >= icount) ? '0 : rp_eff + IAW'(1);
  end

  always_comb begin
    case (state)
      S_FETCH: prog_raddr = PAW'(pc + PCW'(1));
      S_SKIP:  prog_raddr = PAW'(scan + PCW'(1));
      default: prog_raddr = PAW'(pc);
    endcase
  end

  assign prog_we  = accept && (cmd.opcode == OP_LOAD_PROG) &&
                    (pcount != PCW'(PROGRAM_DEPTH));
  assign in_we    = accept && (cmd.opcode == OP_LOAD_INPUT) &&
                    (icount != ICW'(INPUT_DEPTH));
  assign stack_we = (state == S_FETCH) && (instr == CH_OPEN) && (cur_cell != 8'd0) &&
                    (sdepth != SDW'(STACK_DEPTH));

  always_comb begin
    tape_ctl.restart = accept && (cmd.opcode == OP_RESTART);
    tape_ctl.wr_en   = 1'b0;
    tape_wdata       = cur_cell;
    if (state == S_FETCH) begin
      case (instr)
        CH_PLUS: begin
          tape_ctl.wr_en = 1'b1;
          tape_wdata     = cur_cell + 8'd1;
        end
        CH_MINUS: begin
          tape_ctl.wr_en = 1'b1;
          tape_wdata     = cur_cell - 8'd1;
        end
        CH_COMMA: begin
          tape_ctl.wr_en = 1'b1;
          tape_wdata     = (icount == '0) ? 8'd0 : in_rdata;
        end
        default: tape_ctl.wr_en = 1'b0;
      endcase
    end
  end

  bf_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (PAW'(pcount)),
    .wdata (cmd.symbol),
    .raddr (prog_raddr),
    .rdata (instr)
  );

  bf_ram #(.WIDTH(PAW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (SAW'(sdepth)),
    .wdata (PAW'(pc)),
    .raddr (SAW'(sdepth - SDW'(1))),
    .rdata (stack_rdata)
  );

  bf_ram #(.WIDTH(8), .DEPTH(INPUT_DEPTH)) u_input (
    .clk   (clk),
    .we    (in_we),
    .waddr (IAW'(icount)),
    .wdata (cmd.symbol),
    .raddr (rp_eff),
    .rdata (in_rdata)
  );

  bf_tape #(.TAPE_DEPTH(TAPE_DEPTH)) u_tape (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tape_ctl),
    .rd_addr (ptr),
    .wr_addr (ptr),
    .wr_data (tape_wdata),
    .rd_data (cur_cell),
    .busy    (tape_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tape_length <= TAPE_LEN_RESET;
      pc          <= '0;
      pcount      <= '0;
      ptr         <= '0;
      sdepth      <= '0;
      icount      <= '0;
      rp          <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        tape_length <= cfg_data;
      end
      // a finishing command reloads the output register in the same cycle
      if (result.valid && result.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            st     <= ((cmd.opcode == OP_LOAD_PROG && !prog_we) ||
                       (cmd.opcode == OP_LOAD_INPUT && !in_we)) ? ST_FULL : ST_OK;
            emit_v <= 1'b0;
            emit_b <= 8'd0;
            case (opcode_t'(cmd.opcode))
              OP_LOAD_PROG: begin
                if (prog_we) pcount <= pcount + PCW'(1);
                state <= S_DONE;
              end
              OP_LOAD_INPUT: begin
                if (in_we) icount <= icount + ICW'(1);
                state <= S_DONE;
              end
              OP_EXEC: begin
                state <= (pc >= pcount) ? S_DONE : S_FETCH;
              end
              OP_RESTART: begin
                pc     <= '0;
                ptr    <= '0;
                sdepth <= '0;
                rp     <= '0;
                state  <= S_CLEAR;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_FETCH: begin
          if (instr == CH_OPEN && cur_cell == 8'd0) state <= S_SKIP;
          else state <= S_DONE;
          if (instr == CH_CLOSE && sdepth != '0 && cur_cell != 8'd0) begin
            pc <= PCW'(stack_rdata);
          end else begin
            pc <= pc + PCW'(1);
          end
          case (instr)
            CH_RIGHT: begin
              if (LENW'(ptr) + LENW'(1) >= used_len) ptr <= '0;
              else ptr <= ptr + PTRW'(1);
            end
            CH_LEFT: begin
              if (ptr == '0) ptr <= PTRW'(used_len - LENW'(1));
              else ptr <= ptr - PTRW'(1);
            end
            CH_DOT: begin
              emit_v <= 1'b1;
              emit_b <= cur_cell;
            end
            CH_COMMA: begin
              if (icount == '0) st <= ST_NO_INPUT;
              else rp <= rp_adv;
            end
            CH_OPEN: begin
              if (cur_cell == 8'd0) begin
                scan  <= pc + PCW'(1);
                level <= '0;
              end else if (sdepth == SDW'(STACK_DEPTH)) begin
                st <= ST_OVERFLOW;
              end else begin
                sdepth <= sdepth + SDW'(1);
              end
            end
            CH_CLOSE: begin
              if (sdepth == '0) begin
                st <= ST_UNDERFLOW;
              end else begin
                sdepth <= sdepth - SDW'(1);
              end
            end
            CH_BANG: st <= ST_PLUGIN;
            default: st <= ST_OK;
          endcase
        end
        S_SKIP: begin
          // instr holds the symbol at scan, the read of scan+1 is under way
          if (scan >= pcount) begin
            pc    <= pcount;
            state <= S_DONE;
          end else if (instr == CH_CLOSE) begin
            if (level == '0) begin
              pc    <= scan + PCW'(1);
              state <= S_DONE;
            end else begin
              level <= level - PCW'(1);
              scan  <= scan + PCW'(1);
            end
          end else if (instr == CH_OPEN) begin
            level <= level + PCW'(1);
            scan  <= scan + PCW'(1);
          end else begin
            scan <= scan + PCW'(1);
          end
        end
        S_CLEAR: begin
          if (!tape_busy) state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid     <= 1'b1;
            res_out_valid <= emit_v;
            res_out_byte  <= emit_b;
            res_halted    <= (pc >= pcount);
            res_status    <= st;
            res_position  <= 13'(pc);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid            = res_valid;
  assign result.out_valid        = res_out_valid;
  assign result.out_byte         = res_out_byte;
  assign result.halted           = res_halted;
  assign result.status           = res_status;
  assign result.program_position = res_position;

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    (sdepth <= SDW'(STACK_DEPTH)))
    else $error("return stack depth out of range");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (LENW'(ptr) < LENW'(TAPE_DEPTH)))
    else $error("cell pointer beyond tape");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    ($rose(res_valid) |-> $past(state == S_DONE)))
    else $error("result raised outside completion");

  a_skip_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SKIP |-> scan <= pcount))
    else $error("bracket scan passed program end");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (accept |=> state != S_IDLE))
    else $error("command beat did not start work");

endmodule
`default_nettype wire
